// ===== rtl/signed_unsigned_integer_divider_macros.svh =====
// ============================================================================
// Divider assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ============================================================================
`ifndef SIGNED_UNSIGNED_INTEGER_DIVIDER_MACROS_SVH
`define SIGNED_UNSIGNED_INTEGER_DIVIDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divider assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divider assertion failed");

`endif

// ===== rtl/sud_pkg.sv =====
// ============================================================================
// Divider package
// Widths, operation codes and pipeline stage types of the integer divider.
// ============================================================================
`default_nettype none

package sud_pkg;

    localparam int XLEN    = 64;
    localparam int HLEN    = 32;
    // One preparation stage, one stage per quotient bit, one output stage.
    localparam int LATENCY = XLEN + 2;

    localparam logic [1:0] OP_DIVU32 = 2'd0;
    localparam logic [1:0] OP_DIV32  = 2'd1;
    localparam logic [1:0] OP_DIVU64 = 2'd2;
    localparam logic [1:0] OP_DIV64  = 2'd3;

    typedef struct packed {
        logic aneg;
        logic bneg;
        logic dz;
        logic wide;
    } t_ctrl;

    // nq holds the dividend bits still to be consumed in its upper part and
    // the quotient bits already produced in its lower part.
    typedef struct packed {
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] nq;
        logic [XLEN-1:0] d;
        t_ctrl           ctrl;
    } t_stage;

endpackage

`default_nettype wire

// ===== rtl/sud_div_step.sv =====
// ============================================================================
// Divider step stage
// One registered restoring shift-subtract iteration producing one
// quotient bit.
// ============================================================================
`default_nettype none

module sud_div_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire sud_pkg::t_stage i_stage,
    output logic                 o_valid,
    output sud_pkg::t_stage      o_stage
);
    import sud_pkg::*;

    logic            r_valid;
    t_stage          r_stage;
    t_stage          n_stage;
    logic [XLEN:0]   w_shift;
    logic [XLEN:0]   w_dext;
    logic [XLEN:0]   w_diff;
    logic            w_ge;

    // The shifted remainder keeps its carry bit, so divisors at or above
    // half the range still compare correctly.
    assign w_shift = {i_stage.rem, i_stage.nq[XLEN-1]};
    assign w_dext  = {1'b0, i_stage.d};
    assign w_diff  = w_shift - w_dext;
    assign w_ge    = (w_shift >= w_dext);

    always_comb begin
        n_stage      = i_stage;
        n_stage.rem  = w_ge ? w_diff[XLEN-1:0] : w_shift[XLEN-1:0];
        n_stage.nq   = {i_stage.nq[XLEN-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ===== rtl/signed_unsigned_integer_divider.sv =====
// ============================================================================
// Signed and unsigned integer divider
// Pipelined restoring divider for 32- and 64-bit operands giving quotient,
// remainder and a divide-by-zero flag.
// ============================================================================
//
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+----------------------------------
// command  | in        | start, busy         | i_op, i_dividend, i_divisor
// result   | out       | o_valid (strobe)    | o_quotient, o_remainder,
//          |           |                     | o_divide_by_zero
//
// A transfer is accepted on any cycle with start high; busy stays low, so one
// division enters per cycle. Each result passes through a preparation register
// for sign and magnitude, the chain of one-bit subtract stages, and an output
// register for sign correction. The result is held for a single cycle with
// o_valid high. Reset clears only the valid bits of the pipeline; the receiver
// cannot stall.
// ============================================================================
`default_nettype none

module signed_unsigned_integer_divider (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_op,
    input  wire logic [sud_pkg::XLEN-1:0] i_dividend,
    input  wire logic [sud_pkg::XLEN-1:0] i_divisor,
    output logic                          o_valid,
    output logic [sud_pkg::XLEN-1:0]      o_quotient,
    output logic [sud_pkg::XLEN-1:0]      o_remainder,
    output logic                          o_divide_by_zero
);
    import sud_pkg::*;

    `include "signed_unsigned_integer_divider_macros.svh"

    logic            w_accept;
    logic            w_wide;
    logic            w_sgn;
    logic [XLEN-1:0] w_mask;
    logic [XLEN-1:0] w_a;
    logic [XLEN-1:0] w_b;
    logic            w_aneg;
    logic            w_bneg;
    t_stage          n_prep;

    logic            step_valid [0:XLEN];
    t_stage          step_data  [0:XLEN];

    logic            r_prep_valid;
    t_stage          r_prep;

    t_stage          w_last;
    logic [XLEN-1:0] w_q;
    logic [XLEN-1:0] w_r;
    logic            r_out_valid;
    logic [XLEN-1:0] r_quotient;
    logic [XLEN-1:0] r_remainder;
    logic            r_dz;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Preparation: operand masking, sign detection and magnitudes.
    assign w_wide = (i_op == OP_DIVU64) || (i_op == OP_DIV64);
    assign w_sgn  = (i_op == OP_DIV32)  || (i_op == OP_DIV64);
    assign w_mask = w_wide ? {XLEN{1'b1}} : {{(XLEN-HLEN){1'b0}}, {HLEN{1'b1}}};
    assign w_a    = i_dividend & w_mask;
    assign w_b    = i_divisor & w_mask;
    assign w_aneg = w_sgn && (w_wide ? w_a[XLEN-1] : w_a[HLEN-1]);
    assign w_bneg = w_sgn && (w_wide ? w_b[XLEN-1] : w_b[HLEN-1]);

    // In 32-bit modes the upper half of the magnitude is zero, so the first half of
    // the chain shifts zeros and produces zero quotient bits unless the divisor is zero.
    always_comb begin
        n_prep.rem       = '0;
        n_prep.nq        = w_aneg ? ((~w_a + {{(XLEN-1){1'b0}}, 1'b1}) & w_mask) : w_a;
        n_prep.d         = w_bneg ? ((~w_b + {{(XLEN-1){1'b0}}, 1'b1}) & w_mask) : w_b;
        n_prep.ctrl.aneg = w_aneg;
        n_prep.ctrl.bneg = w_bneg;
        n_prep.ctrl.dz   = (w_b == '0);
        n_prep.ctrl.wide = w_wide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else begin
            r_prep_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prep <= n_prep;
    end

    assign step_valid[0] = r_prep_valid;
    assign step_data[0]  = r_prep;

    for (genvar g = 0; g < XLEN; g++) begin : g_step
        sud_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (step_valid[g]),
            .i_stage (step_data[g]),
            .o_valid (step_valid[g+1]),
            .o_stage (step_data[g+1])
        );
    end

    // Output: sign correction, width masking and the zero-divisor case.
    assign w_last = step_data[XLEN];

    always_comb begin
        w_q = (w_last.ctrl.aneg ^ w_last.ctrl.bneg) ? (~w_last.nq + {{(XLEN-1){1'b0}}, 1'b1})
                                                    : w_last.nq;
        w_r = w_last.ctrl.aneg ? (~w_last.rem + {{(XLEN-1){1'b0}}, 1'b1}) : w_last.rem;
        if (!w_last.ctrl.wide) begin
            w_q = {{(XLEN-HLEN){1'b0}}, w_q[HLEN-1:0]};
            w_r = {{(XLEN-HLEN){1'b0}}, w_r[HLEN-1:0]};
        end
        if (w_last.ctrl.dz) begin
            w_q = '0;
            w_r = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step_valid[XLEN];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quotient  <= w_q;
        r_remainder <= w_r;
        r_dz        <= w_last.ctrl.dz;
    end

    assign o_valid          = r_out_valid;
    assign o_quotient       = r_quotient;
    assign o_remainder      = r_remainder;
    assign o_divide_by_zero = r_dz;

    `SUD_ASSERT_SAME(a_result_follows_command, i_clk, i_rst_n, o_valid, $past(w_accept, LATENCY))
    `SUD_ASSERT_SAME(a_rem_below_divisor, i_clk, i_rst_n, step_valid[XLEN] && !w_last.ctrl.dz, w_last.rem < w_last.d)
    `SUD_ASSERT_SAME(a_dz_results_zero, i_clk, i_rst_n, o_valid && o_divide_by_zero, (o_quotient == '0) && (o_remainder == '0))

endmodule

`default_nettype wire

// ===== verif/signed_unsigned_integer_divider_test.sv =====
// ============================================================================
// Integer divider testbench
// Sends directed and random divisions in random bursts, predicts the
// quotient, remainder and divide-by-zero flag of each one with a bit-serial
// restoring division, and checks every result strobe in order.
// ============================================================================
`timescale 1ns / 100ps

module signed_unsigned_integer_divider_test;

    import sud_pkg::*;

    typedef struct {
        logic [1:0]      op;
        logic [XLEN-1:0] num;
        logic [XLEN-1:0] den;
    } t_div_cmd;

    typedef struct {
        logic [XLEN-1:0] quot;
        logic [XLEN-1:0] rem;
        logic            dz;
    } t_div_result;

    localparam logic [XLEN-1:0] MASK_LO  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [XLEN-1:0] MIN64    = 64'h8000_0000_0000_0000;
    localparam logic [XLEN-1:0] MAX64    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [XLEN-1:0] MIN32    = 64'h0000_0000_8000_0000;
    localparam logic [XLEN-1:0] MAX32    = 64'h0000_0000_7FFF_FFFF;
    localparam logic [XLEN-1:0] ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int              N_RANDOM = 2000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic [1:0]      i_op = OP_DIVU32;
    logic [XLEN-1:0] i_dividend = '0;
    logic [XLEN-1:0] i_divisor = '0;
    logic            busy;
    logic            o_valid;
    logic [XLEN-1:0] o_quotient;
    logic [XLEN-1:0] o_remainder;
    logic            o_divide_by_zero;

    t_div_cmd    pending_cmds[$];
    t_div_result expected_results[$];
    logic [1:0]  op_codes[4] = '{OP_DIVU32, OP_DIV32, OP_DIVU64, OP_DIV64};

    logic        handed_over = 1'b0;
    int          n_accepted = 0;
    int          n_errors = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          n_total;
    t_div_cmd    next_cmd;
    t_div_result got, want;

    signed_unsigned_integer_divider dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_valid          (o_valid),
        .o_quotient       (o_quotient),
        .o_remainder      (o_remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sign handling around an unsigned restoring division at the operand width.
    function automatic t_div_result divide_expected(logic [1:0] op, logic [XLEN-1:0] num,
                                                    logic [XLEN-1:0] den);
        t_div_result     res;
        logic            wide, sgn, num_neg, den_neg, carry;
        logic [XLEN-1:0] mask, a, b, q, r;
        int              width, k;
        wide  = (op == OP_DIVU64) || (op == OP_DIV64);
        sgn   = (op == OP_DIV32) || (op == OP_DIV64);
        width = wide ? XLEN : HLEN;
        mask  = wide ? ONES : MASK_LO;
        a = num & mask;
        b = den & mask;
        num_neg = sgn && a[width-1];
        den_neg = sgn && b[width-1];
        if (num_neg) a = (-a) & mask;
        if (den_neg) b = (-b) & mask;
        q = '0;
        r = '0;
        res.dz = (b == '0);
        if (!res.dz) begin
            for (k = width - 1; k >= 0; k--) begin
                // The bit shifted out of the partial remainder still counts,
                // which matters for divisors at or above 2^63.
                carry = r[XLEN-1];
                r = {r[XLEN-2:0], a[k]};
                if (carry || r >= b) begin
                    r = r - b;
                    q[k] = 1'b1;
                end
            end
            if (num_neg != den_neg) q = -q;
            if (num_neg) r = -r;
        end
        res.quot = q & mask;
        res.rem  = r & mask;
        return res;
    endfunction

    function automatic logic [XLEN-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [XLEN-1:0] rand_extreme();
        case ($urandom_range(0, 8))
            0: return '0;
            1: return 64'd1;
            2: return ONES;
            3: return MIN64;
            4: return MAX64;
            5: return MIN32;
            6: return MAX32;
            7: return MASK_LO;
            default: return {$urandom, 32'h0} | MIN32;
        endcase
    endfunction

    task automatic add_cmd(logic [1:0] op, logic [XLEN-1:0] num, logic [XLEN-1:0] den);
        t_div_cmd c;
        c.op  = op;
        c.num = num;
        c.den = den;
        pending_cmds.push_back(c);
    endtask

    task automatic report_mismatch(string field, logic [XLEN-1:0] exp_val,
                                   logic [XLEN-1:0] got_val);
        $display("mismatch at %0t: %s expected %h got %h", $realtime, field, exp_val, got_val);
        n_errors++;
    endtask

    // Driver: holds each command until the block takes it, then moves on.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || handed_over)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
                next_cmd = pending_cmds.pop_front();
                i_op       <= next_cmd.op;
                i_dividend <= next_cmd.num;
                i_divisor  <= next_cmd.den;
                start      <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: records each accepted transfer and checks each result strobe.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            handed_over <= 1'b0;
        end else begin
            handed_over <= start && !busy;
            if (start && !busy) begin
                expected_results.push_back(divide_expected(i_op, i_dividend, i_divisor));
                n_accepted <= n_accepted + 1;
            end
            if (o_valid) begin
                got.quot = o_quotient;
                got.rem  = o_remainder;
                got.dz   = o_divide_by_zero;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result quotient", '0, got.quot);
                end else begin
                    want = expected_results.pop_front();
                    if (got.quot !== want.quot)
                        report_mismatch("quotient", want.quot, got.quot);
                    if (got.rem !== want.rem)
                        report_mismatch("remainder", want.rem, got.rem);
                    if (got.dz !== want.dz)
                        report_mismatch("divide_by_zero", {{(XLEN-1){1'b0}}, want.dz},
                                        {{(XLEN-1){1'b0}}, got.dz});
                end
            end
        end
    end

    initial begin
        logic [1:0]      op;
        logic [XLEN-1:0] num, den;
        int              i;

        // Directed part: signs, extremes, zero divisors and overflow.
        add_cmd(OP_DIVU32, 64'd100, 64'd7);
        add_cmd(OP_DIV32,  64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
        add_cmd(OP_DIV32,  64'd7, 64'h0000_0000_FFFF_FFFE);
        add_cmd(OP_DIV32,  64'h0000_0000_FFFF_FFF9, 64'h0000_0000_FFFF_FFFE);
        add_cmd(OP_DIV64,  -64'sd7, 64'd2);
        add_cmd(OP_DIV64,  64'd7, -64'sd2);
        add_cmd(OP_DIV64,  -64'sd7, -64'sd2);
        add_cmd(OP_DIVU32, 64'd5, 64'd0);
        add_cmd(OP_DIV32,  64'd5, 64'hABCD_0123_0000_0000);
        add_cmd(OP_DIVU64, ONES, 64'd0);
        add_cmd(OP_DIV64,  MIN64, 64'd0);
        add_cmd(OP_DIV32,  MIN32, MASK_LO);
        add_cmd(OP_DIV64,  MIN64, ONES);
        add_cmd(OP_DIVU64, ONES, MIN64);
        add_cmd(OP_DIVU64, ONES, ONES);
        add_cmd(OP_DIVU64, 64'h8000_0000_0000_0005, 64'hC000_0000_0000_0000);
        add_cmd(OP_DIVU64, ONES, 64'd1);
        add_cmd(OP_DIVU32, 64'hDEAD_BEEF_FFFF_FFFF, 64'h1234_5678_0000_0001);
        add_cmd(OP_DIV32,  64'h5555_AAAA_7FFF_FFFF, 64'hAAAA_5555_8000_0000);
        add_cmd(OP_DIV64,  MAX64, MIN64);
        add_cmd(OP_DIV64,  64'd0, ONES);
        add_cmd(OP_DIVU32, 64'd0, MASK_LO);
        add_cmd(OP_DIVU64, 64'd3, 64'd10);

        for (i = 0; i < N_RANDOM; i++) begin
            op  = op_codes[$urandom_range(0, 3)];
            num = rand64();
            den = rand64();
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3: den = den >> $urandom_range(0, 63);
                4: begin
                    num = {{48{num[15]}}, num[15:0]};
                    den = {{56{den[7]}}, den[7:0]};
                    if ($urandom_range(0, 1) == 1) begin
                        num[63:32] = $urandom;
                        den[63:32] = $urandom;
                    end
                end
                5: begin
                    num = rand_extreme();
                    den = rand_extreme();
                end
                6: den = ($urandom_range(0, 1) == 1) ? '0 : {$urandom, 32'h0};
                7: den[63] = 1'b1;
                8: begin
                    num = ($urandom_range(0, 1) == 1) ? MIN64 : {$urandom, MIN32[31:0]};
                    den = ($urandom_range(0, 1) == 1) ? ONES : {$urandom, 32'hFFFF_FFFF};
                end
                default: den = num + 64'($signed($urandom_range(0, 6)) - 3);
            endcase
            add_cmd(op, num, den);
        end
        n_total = pending_cmds.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sud_pkg.sv
rtl/sud_div_step.sv
rtl/signed_unsigned_integer_divider.sv
verif/signed_unsigned_integer_divider_test.sv
